// ===== hw/rtl/epg_pkg.sv =====
package epg_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 12;
  localparam int COLOR_BITS  = 8;
  localparam int DOT_BITS    = COORD_BITS + 1;
  localparam int POS_BITS    = RADIUS_BITS + 1;
  localparam int ERR_BITS    = RADIUS_BITS + 3;
  localparam int PROD_BITS   = 2 * RADIUS_BITS;
  localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Request into the shared divider.
  typedef struct packed {
    logic                   start;
    logic [PROD_BITS-1:0]   dividend;
    logic [RADIUS_BITS-1:0] divisor;
  } epg_div_req_t;

  // Status back from the shared divider.
  typedef struct packed {
    logic                 done;
    logic [PROD_BITS-1:0] quotient;
  } epg_div_sts_t;

endpackage

// ===== hw/rtl/epg_divider.sv =====
module epg_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  epg_pkg::epg_div_req_t req,
  output epg_pkg::epg_div_sts_t sts
);

  logic                                busy_r;
  logic                                done_r;
  logic [epg_pkg::DIV_CNT_BITS-1:0]    cnt_r;
  logic [epg_pkg::RADIUS_BITS-1:0]     rem_r;
  logic [epg_pkg::RADIUS_BITS-1:0]     dvs_r;
  logic [epg_pkg::PROD_BITS-1:0]       quo_r;

  logic [epg_pkg::RADIUS_BITS:0]       trial;
  logic [epg_pkg::RADIUS_BITS:0]       diff;
  logic                                fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_r, quo_r[epg_pkg::PROD_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= epg_pkg::DIV_CNT_BITS'(epg_pkg::PROD_BITS);
        rem_r  <= '0;
        dvs_r  <= req.divisor;
        quo_r  <= req.dividend;
      end else if (busy_r) begin
        rem_r <= fits ? diff[epg_pkg::RADIUS_BITS-1:0] : trial[epg_pkg::RADIUS_BITS-1:0];
        quo_r <= {quo_r[epg_pkg::PROD_BITS-2:0], fits};
        cnt_r <= cnt_r - epg_pkg::DIV_CNT_BITS'(1);
        if (cnt_r == epg_pkg::DIV_CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

// ===== hw/rtl/ellipse_point_generator_core.sv =====
// Ellipse point generator: midpoint circle of the major radius, with the
// minor-axis offsets scaled by minor/major (truncating).
//
// Input channel (in_valid / in_stall): a start transfer (command 0) loads
// center, radii and color and gives no dots. A step transfer (command 1)
// gives one iteration's eight mirrored dots; a step while idle gives none.
// A start while an ellipse runs drops it and loads the new one.
// Result channel (out_valid / out_stall): one dot per transfer, last_of_step
// on the eighth, ellipse_done on every dot of the final iteration.
//
// Start items and idle steps are taken in the idle state and start no work.
// A working step computes two scaled offsets in turn, each by a multiply,
// a launch, the bit-serial shared divider and a collect of its quotient,
// then hands out the eight dots.
// in_stall stays high from the step transfer until the eighth dot is loaded
// into the output register; the next item may be taken while that dot waits.
// A stalled receiver holds the current dot and pauses the dot sequence.
// Reset (rst_n low, synchronous) clears the ellipse state, drops any
// pending dot and returns to idle.
module ellipse_point_generator_core (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_command,
  input  logic signed [epg_pkg::COORD_BITS-1:0] in_center_x,
  input  logic signed [epg_pkg::COORD_BITS-1:0] in_center_y,
  input  logic        [epg_pkg::RADIUS_BITS-1:0] in_radius_x,
  input  logic        [epg_pkg::RADIUS_BITS-1:0] in_radius_y,
  input  logic        [epg_pkg::COLOR_BITS-1:0] in_color,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [epg_pkg::DOT_BITS-1:0]   out_dot_x,
  output logic signed [epg_pkg::DOT_BITS-1:0]   out_dot_y,
  output logic        [epg_pkg::COLOR_BITS-1:0] out_dot_color,
  output logic                                  out_last_of_step,
  output logic                                  out_ellipse_done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  localparam int R   = epg_pkg::RADIUS_BITS;
  localparam int PB  = epg_pkg::POS_BITS;
  localparam int EB  = epg_pkg::ERR_BITS;
  localparam int DB  = epg_pkg::DOT_BITS;
  localparam int CB  = epg_pkg::COORD_BITS;

  state_t state_r;

  // Ellipse state
  logic                  active_r;
  logic                  major_on_x_r;
  logic signed [PB-1:0]  major_pos_r;
  logic signed [PB-1:0]  minor_pos_r;
  logic signed [EB-1:0]  error_r;
  logic signed [CB-1:0]  cx_r;
  logic signed [CB-1:0]  cy_r;
  logic [R-1:0]          rmaj_r;
  logic [R-1:0]          rmin_r;
  logic [epg_pkg::COLOR_BITS-1:0] color_r;

  // Per-step working registers
  logic signed [PB-1:0]  a_r;
  logic signed [PB-1:0]  b_r;
  logic                  last_r;
  logic                  sel_b_r;
  logic [epg_pkg::PROD_BITS-1:0] prod_r;
  logic [PB-1:0]         sa_r;
  logic [PB-1:0]         sb_r;
  logic [2:0]            dot_cnt_r;

  // Output register
  logic                  out_valid_r;
  logic signed [DB-1:0]  dot_x_r;
  logic signed [DB-1:0]  dot_y_r;
  logic [epg_pkg::COLOR_BITS-1:0] dot_color_r;
  logic                  last_of_step_r;
  logic                  ellipse_done_r;

  epg_pkg::epg_div_req_t div_req;
  epg_pkg::epg_div_sts_t div_sts;

  logic                  in_xfer;
  logic                  out_take;
  logic                  dot_load;

  // Next iteration of the midpoint circle
  logic signed [EB-1:0]  a_e;
  logic signed [EB-1:0]  b_e;
  logic signed [EB-1:0]  err_dec;
  logic signed [EB-1:0]  err_inc;
  logic signed [PB-1:0]  major_step;
  logic signed [PB-1:0]  minor_step;
  logic                  step_last;

  // Multiply operand and divider result
  logic signed [PB-1:0]  mul_p;
  logic [R-1:0]          mul_op;
  logic [PB-1:0]         scaled;

  // Dot assembly
  logic                  start_major_on_x;
  logic signed [DB-1:0]  ax_e;
  logic signed [DB-1:0]  bx_e;
  logic signed [DB-1:0]  sa_e;
  logic signed [DB-1:0]  sb_e;
  logic signed [DB-1:0]  mag_x;
  logic signed [DB-1:0]  mag_y;
  logic signed [DB-1:0]  off_x;
  logic signed [DB-1:0]  off_y;
  logic signed [DB-1:0]  dot_x;
  logic signed [DB-1:0]  dot_y;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign dot_load = (state_r == S_EMIT) && (!out_valid_r || out_take);

  assign a_e        = {{(EB-PB){major_pos_r[PB-1]}}, major_pos_r};
  assign b_e        = {{(EB-PB){minor_pos_r[PB-1]}}, minor_pos_r};
  assign err_dec    = error_r - (b_e <<< 1) + EB'(1);
  assign err_inc    = err_dec + ((a_e - EB'(1)) <<< 1);
  assign minor_step = minor_pos_r + PB'(1);
  assign major_step = err_dec[EB-1] ? (major_pos_r - PB'(1)) : major_pos_r;
  assign step_last  = major_step < minor_step;

  // Non-positive positions scale to zero.
  assign mul_p  = sel_b_r ? b_r : a_r;
  assign mul_op = (!mul_p[PB-1] && (mul_p != '0)) ? mul_p[R-1:0] : '0;

  assign div_req.start    = (state_r == S_DIV_GO);
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = rmaj_r;

  // A zero major radius means both radii are zero: offsets are zero.
  assign scaled = (rmaj_r == '0) ? '0 : div_sts.quotient[PB-1:0];

  epg_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  assign start_major_on_x = in_radius_x > in_radius_y;

  assign ax_e = {{(DB-PB){a_r[PB-1]}}, a_r};
  assign bx_e = {{(DB-PB){b_r[PB-1]}}, b_r};
  assign sa_e = {{(DB-PB){1'b0}}, sa_r};
  assign sb_e = {{(DB-PB){1'b0}}, sb_r};

  // Dots 0-3 mirror the major-position octant, 4-7 the minor one;
  // bit 1 of the count negates x, bit 0 negates y.
  always_comb begin
    if (major_on_x_r) begin
      mag_x = dot_cnt_r[2] ? bx_e : ax_e;
      mag_y = dot_cnt_r[2] ? sa_e : sb_e;
    end else begin
      mag_x = dot_cnt_r[2] ? sb_e : sa_e;
      mag_y = dot_cnt_r[2] ? ax_e : bx_e;
    end
    off_x = dot_cnt_r[1] ? -mag_x : mag_x;
    off_y = dot_cnt_r[0] ? -mag_y : mag_y;
    dot_x = {cx_r[CB-1], cx_r} + off_x;
    dot_y = {cy_r[CB-1], cy_r} + off_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= 1'b0;
      major_on_x_r <= 1'b0;
      major_pos_r  <= '0;
      minor_pos_r  <= '0;
      error_r      <= '0;
      cx_r         <= '0;
      cy_r         <= '0;
      rmaj_r       <= '0;
      rmin_r       <= '0;
      color_r      <= '0;
      sel_b_r      <= 1'b0;
      dot_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // Drain the output register unless a new dot is loaded below.
      if (out_take && !dot_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_command == epg_pkg::CMD_START) begin
              cx_r         <= in_center_x;
              cy_r         <= in_center_y;
              color_r      <= in_color;
              major_on_x_r <= start_major_on_x;
              rmaj_r       <= start_major_on_x ? in_radius_x : in_radius_y;
              rmin_r       <= start_major_on_x ? in_radius_y : in_radius_x;
              major_pos_r  <= {1'b0, (start_major_on_x ? in_radius_x : in_radius_y)};
              minor_pos_r  <= '0;
              error_r      <= {{(EB-R){1'b0}},
                               (start_major_on_x ? in_radius_x : in_radius_y)};
              active_r     <= 1'b1;
            end else if (active_r) begin
              // Latch this iteration's positions, advance the circle.
              a_r         <= major_pos_r;
              b_r         <= minor_pos_r;
              last_r      <= step_last;
              minor_pos_r <= minor_step;
              major_pos_r <= major_step;
              error_r     <= err_dec[EB-1] ? err_inc : err_dec;
              if (step_last) begin
                active_r <= 1'b0;
              end
              sel_b_r <= 1'b0;
              state_r <= S_MUL;
            end
          end
        end

        S_MUL: begin
          prod_r  <= epg_pkg::PROD_BITS'(mul_op) * epg_pkg::PROD_BITS'(rmin_r);
          state_r <= S_DIV_GO;
        end

        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_sts.done) begin
            if (sel_b_r) begin
              sb_r      <= scaled;
              dot_cnt_r <= '0;
              state_r   <= S_EMIT;
            end else begin
              sa_r    <= scaled;
              sel_b_r <= 1'b1;
              state_r <= S_MUL;
            end
          end
        end

        S_EMIT: begin
          if (dot_load) begin
            out_valid_r    <= 1'b1;
            dot_x_r        <= dot_x;
            dot_y_r        <= dot_y;
            dot_color_r    <= color_r;
            last_of_step_r <= (dot_cnt_r == 3'd7);
            ellipse_done_r <= last_r;
            dot_cnt_r      <= dot_cnt_r + 3'd1;
            if (dot_cnt_r == 3'd7) begin
              state_r <= S_IDLE;
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dot_x        = dot_x_r;
  assign out_dot_y        = dot_y_r;
  assign out_dot_color    = dot_color_r;
  assign out_last_of_step = last_of_step_r;
  assign out_ellipse_done = ellipse_done_r;

  // A divider result only arrives while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV_WAIT))
    else $error("divider finished outside the wait state");

  // A step transfer on a running ellipse launches the multiply.
  a_step_launches: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_command == epg_pkg::CMD_STEP) && active_r) |=> (state_r == S_MUL))
    else $error("step transfer did not start the iteration");

  // New dots only come out of the dot sequence.
  a_dot_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == S_EMIT))
    else $error("dot loaded outside the dot sequence");

  // The ellipse ends only on an item transfer.
  a_active_falls_on_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(active_r)) |-> $past(in_xfer))
    else $error("ellipse ended without an item transfer");

endmodule

// ===== tb/ellipse_point_generator_core_tb.sv =====
`timescale 1ns / 100ps

module ellipse_point_generator_core_tb;

  localparam int IDLE_PCT   = 21;    // idle / stall chance per cycle, in percent
  localparam int RAND_ITEMS = 500;   // working items in the random part
  localparam int DIR_ROWS   = 24;
  localparam int WDOG_LIMIT = 2000;  // cycles with no transfer on either channel
  localparam int DRAIN_WAIT = 60;    // settle time after the owed dots drain
  localparam int SHOW_MAX   = 10;

  // One input item, plus an optional typed expectation for its first dot.
  // On typed step rows the color field carries the expected dot color; the
  // block ignores color on a step.
  typedef struct packed {
    logic                                   cmd;
    logic signed [epg_pkg::COORD_BITS-1:0]  cx;
    logic signed [epg_pkg::COORD_BITS-1:0]  cy;
    logic        [epg_pkg::RADIUS_BITS-1:0] rx;
    logic        [epg_pkg::RADIUS_BITS-1:0] ry;
    logic        [epg_pkg::COLOR_BITS-1:0]  color;
    logic                                   typed;
    logic signed [epg_pkg::DOT_BITS-1:0]    ex;
    logic signed [epg_pkg::DOT_BITS-1:0]    ey;
    logic                                   edone;
  } ell_row_t;

  typedef struct packed {
    logic signed [epg_pkg::DOT_BITS-1:0]   x;
    logic signed [epg_pkg::DOT_BITS-1:0]   y;
    logic        [epg_pkg::COLOR_BITS-1:0] color;
    logic                                  last_step;
    logic                                  ell_done;
  } dot_t;

  logic                                   clk;
  logic                                   rst_n;
  logic                                   in_valid;
  logic                                   in_stall;
  logic                                   in_command;
  logic signed [epg_pkg::COORD_BITS-1:0]  in_center_x;
  logic signed [epg_pkg::COORD_BITS-1:0]  in_center_y;
  logic        [epg_pkg::RADIUS_BITS-1:0] in_radius_x;
  logic        [epg_pkg::RADIUS_BITS-1:0] in_radius_y;
  logic        [epg_pkg::COLOR_BITS-1:0]  in_color;
  logic                                   out_valid;
  logic                                   out_stall;
  logic signed [epg_pkg::DOT_BITS-1:0]    out_dot_x;
  logic signed [epg_pkg::DOT_BITS-1:0]    out_dot_y;
  logic        [epg_pkg::COLOR_BITS-1:0]  out_dot_color;
  logic                                   out_last_of_step;
  logic                                   out_ellipse_done;

  ellipse_point_generator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius_x      (in_radius_x),
    .in_radius_y      (in_radius_y),
    .in_color         (in_color),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dot_x        (out_dot_x),
    .out_dot_y        (out_dot_y),
    .out_dot_color    (out_dot_color),
    .out_last_of_step (out_last_of_step),
    .out_ellipse_done (out_ellipse_done)
  );

  // Shadow copy of the ellipse state, advanced once per accepted input item.
  bit                             ell_active;
  bit                             ell_major_x;
  int                             maj_pos;
  int                             min_pos;
  int                             err_acc;
  int                             ctr_x;
  int                             ctr_y;
  int                             r_major;
  int                             r_minor;
  logic [epg_pkg::COLOR_BITS-1:0] ell_color;

  dot_t     iter_dots [8];     // dots of the latest iteration
  dot_t     pending_dots [$];  // dots still owed by the block, oldest first
  ell_row_t dir_rows [DIR_ROWS];
  int       work_items;        // starts and steps that do real work
  int       mismatch_cnt;
  int       dots_seen;
  int       quiet_cnt;         // cycles since the last transfer
  bit       quiet;             // hold both sides busy: no gaps, no stalls

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ell_row_t row_of(logic cmd, int cx, int cy, int rx, int ry, int color,
                                      bit typed, int ex, int ey, bit edone);
    ell_row_t r;
    r.cmd   = cmd;
    r.cx    = epg_pkg::COORD_BITS'(cx);
    r.cy    = epg_pkg::COORD_BITS'(cy);
    r.rx    = epg_pkg::RADIUS_BITS'(rx);
    r.ry    = epg_pkg::RADIUS_BITS'(ry);
    r.color = epg_pkg::COLOR_BITS'(color);
    r.typed = typed;
    r.ex    = epg_pkg::DOT_BITS'(ex);
    r.ey    = epg_pkg::DOT_BITS'(ey);
    r.edone = edone;
    return r;
  endfunction

  // Scale a major-axis offset into minor-axis units, truncating.
  function automatic int scale_offset(int p);
    if (r_major == 0 || p <= 0) return 0;
    return (p * r_minor) / r_major;
  endfunction

  // Advance the shadow ellipse by one item; return the number of dots owed.
  function automatic int rasterize_item(ell_row_t r);
    int a, b, sa, sb, mx, my, sgn_x, sgn_y;
    bit fin;
    if (r.cmd == epg_pkg::CMD_START) begin
      ctr_x       = r.cx;
      ctr_y       = r.cy;
      ell_color   = r.color;
      ell_major_x = r.rx > r.ry;
      r_major     = ell_major_x ? int'(r.rx) : int'(r.ry);
      r_minor     = ell_major_x ? int'(r.ry) : int'(r.rx);
      maj_pos     = r_major;
      min_pos     = 0;
      err_acc     = r_major;
      ell_active  = 1'b1;
      work_items++;
      return 0;
    end
    // Drop a step while idle: it changes nothing.
    if (!ell_active) return 0;
    work_items++;
    a  = maj_pos;
    b  = min_pos;
    sa = scale_offset(a);
    sb = scale_offset(b);
    err_acc -= 2 * b - 1;
    min_pos  = b + 1;
    if (err_acc < 0) begin
      err_acc += 2 * (a - 1);
      maj_pos  = a - 1;
    end
    fin = maj_pos < min_pos;
    if (fin) ell_active = 1'b0;
    // Mirror order: the first four dots use (a, sb) or (sa, b), the last four
    // swap the roles; bit 1 of the index flips x, bit 0 flips y.
    for (int k = 0; k < 8; k++) begin
      sgn_x = k[1] ? -1 : 1;
      sgn_y = k[0] ? -1 : 1;
      if (ell_major_x) begin
        mx = (k < 4) ? a : b;
        my = (k < 4) ? sb : sa;
      end else begin
        mx = (k < 4) ? sa : sb;
        my = (k < 4) ? b : a;
      end
      iter_dots[k].x         = epg_pkg::DOT_BITS'(ctr_x + sgn_x * mx);
      iter_dots[k].y         = epg_pkg::DOT_BITS'(ctr_y + sgn_y * my);
      iter_dots[k].color     = ell_color;
      iter_dots[k].last_step = (k == 7);
      iter_dots[k].ell_done  = fin;
    end
    return 8;
  endfunction

  // Present one item, hold it until the transfer, then log the dots it owes.
  task automatic send_item(input ell_row_t r);
    int   n;
    dot_t typed_dot;
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= r.cmd;
    in_center_x <= r.cx;
    in_center_y <= r.cy;
    in_radius_x <= r.rx;
    in_radius_y <= r.ry;
    in_color    <= r.color;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = rasterize_item(r);
    for (int k = 0; k < n; k++) begin
      if (k == 0 && r.typed) begin
        typed_dot.x         = r.ex;
        typed_dot.y         = r.ey;
        typed_dot.color     = r.color;
        typed_dot.last_step = 1'b0;
        typed_dot.ell_done  = r.edone;
        pending_dots.push_back(typed_dot);
      end else begin
        pending_dots.push_back(iter_dots[k]);
      end
    end
  endtask

  // Random content everywhere; the caller picks the command and may override the radii.
  function automatic ell_row_t rand_row(logic cmd);
    ell_row_t r;
    r       = '0;
    r.cmd   = cmd;
    r.cx    = epg_pkg::COORD_BITS'($urandom);
    r.cy    = epg_pkg::COORD_BITS'($urandom);
    r.rx    = epg_pkg::RADIUS_BITS'($urandom);
    r.ry    = epg_pkg::RADIUS_BITS'($urandom);
    r.color = epg_pkg::COLOR_BITS'($urandom);
    return r;
  endfunction

  // Receiver: stall at random except in the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Check every dot transfer against the oldest owed dot.
  always @(posedge clk) begin
    dot_t want;
    if (rst_n && out_valid && !out_stall) begin
      dots_seen++;
      if (pending_dots.size() == 0) begin
        if (mismatch_cnt < SHOW_MAX)
          $display("dot %0d: unexpected, got x=%0d y=%0d color=%0d last=%0b done=%0b",
                   dots_seen, out_dot_x, out_dot_y, out_dot_color,
                   out_last_of_step, out_ellipse_done);
        mismatch_cnt++;
      end else begin
        want = pending_dots.pop_front();
        if (out_dot_x !== want.x || out_dot_y !== want.y || out_dot_color !== want.color ||
            out_last_of_step !== want.last_step || out_ellipse_done !== want.ell_done) begin
          if (mismatch_cnt < SHOW_MAX)
            $display({"dot %0d: expected x=%0d y=%0d color=%0d last=%0b done=%0b, ",
                      "got x=%0d y=%0d color=%0d last=%0b done=%0b"},
                     dots_seen, want.x, want.y, want.color, want.last_step, want.ell_done,
                     out_dot_x, out_dot_y, out_dot_color, out_last_of_step, out_ellipse_done);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel transfers for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= WDOG_LIMIT) begin
      $display("ellipse_point_generator_core: mismatch");
      $finish;
    end
  end

  initial begin
    ell_row_t r;
    int       sel;
    int       steps_cap;
    int       n;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= epg_pkg::CMD_START;
    in_center_x  <= '0;
    in_center_y  <= '0;
    in_radius_x  <= '0;
    in_radius_y  <= '0;
    in_color     <= '0;
    out_stall    <= 1'b0;
    quiet        = 1'b0;
    quiet_cnt    = 0;
    work_items   = 0;
    mismatch_cnt = 0;
    dots_seen    = 0;
    ell_active   = 1'b0;
    ell_major_x  = 1'b0;
    maj_pos      = 0;
    min_pos      = 0;
    err_acc      = 0;
    ctr_x        = 0;
    ctr_y        = 0;
    r_major      = 0;
    r_minor      = 0;
    ell_color    = '0;

    // Directed rows: typed first dots only where the offset is plain to see.
    dir_rows[0]  = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);
    // Both radii zero: every dot lands on the center in one final iteration.
    dir_rows[1]  = row_of(epg_pkg::CMD_START,     0,     0,    0,    0,    0, 0,  0,  0, 0);
    dir_rows[2]  = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 1,  0,  0, 1);
    dir_rows[3]  = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);
    // Largest equal radii at the far corner: vertical major, sa equals a.
    dir_rows[4]  = row_of(epg_pkg::CMD_START,  2047, -2048, 1023, 1023,  255, 0,  0,  0, 0);
    dir_rows[5]  = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,  255, 1,
                          3070, -2048, 0);
    dir_rows[6]  = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);
    // Start while active: replace with a flat horizontal ellipse.
    dir_rows[7]  = row_of(epg_pkg::CMD_START, -2048,  2047, 1023,    0, 8'hAA, 0, 0, 0, 0);
    dir_rows[8]  = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0, 8'hAA, 1,
                          -1025, 2047, 0);
    dir_rows[9]  = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);
    // Zero horizontal radius: vertical major, scaled offsets stay at zero.
    dir_rows[10] = row_of(epg_pkg::CMD_START,  1365, -1366,    0, 1023, 8'h55, 0, 0, 0, 0);
    dir_rows[11] = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0, 8'h55, 1,
                          1365, -1366, 0);
    // Unit circle: two iterations, then a step while idle.
    dir_rows[12] = row_of(epg_pkg::CMD_START,    -1,     1,    1,    1,    1, 0,  0,  0, 0);
    dir_rows[13] = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);
    dir_rows[14] = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);
    dir_rows[15] = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);
    dir_rows[16] = row_of(epg_pkg::CMD_START,   100,  -100,    3,    1, 8'h0F, 0, 0, 0, 0);
    dir_rows[17] = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);
    dir_rows[18] = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);
    dir_rows[19] = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);
    dir_rows[20] = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);
    dir_rows[21] = row_of(epg_pkg::CMD_START, -1366,  1365,  682,  341, 8'hF0, 0, 0, 0, 0);
    dir_rows[22] = row_of(epg_pkg::CMD_STEP,   2047, -2048, 1023, 1023,  255, 0,  0,  0, 0);
    dir_rows[23] = row_of(epg_pkg::CMD_STEP,      0,     0,    0,    0,    0, 0,  0,  0, 0);

    // Hold reset once, then release it.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) send_item(dir_rows[i]);

    // Random part: mostly complete ellipses of small radius, some cut short
    // by a new start, a few huge ones abandoned early, and stray steps.
    work_items = 0;
    while (work_items < RAND_ITEMS) begin
      quiet = (work_items >= 150 && work_items < 300);
      r   = rand_row(epg_pkg::CMD_START);
      sel = $urandom_range(99);
      if (sel < 4) begin
        steps_cap = $urandom_range(30, 1);
      end else begin
        if (sel < 14) begin
          r.rx = epg_pkg::RADIUS_BITS'($urandom_range(60));
          r.ry = epg_pkg::RADIUS_BITS'($urandom_range(60));
        end else begin
          r.rx = epg_pkg::RADIUS_BITS'($urandom_range(15));
          r.ry = epg_pkg::RADIUS_BITS'($urandom_range(15));
        end
        // Cut about a fifth of the ellipses short; run the rest to the end.
        steps_cap = ($urandom_range(99) < 20) ? $urandom_range(6) : 100000;
      end
      if ($urandom_range(9) == 0) r.ry = r.rx;
      if ($urandom_range(19) == 0) begin
        r.rx = '0;
        r.ry = '0;
      end
      send_item(r);
      n = 0;
      while (ell_active && n < steps_cap) begin
        send_item(rand_row(epg_pkg::CMD_STEP));
        n++;
      end
      // Stray steps: more work on a cut ellipse, or ignored when idle.
      repeat ($urandom_range(2)) send_item(rand_row(epg_pkg::CMD_STEP));
    end
    quiet = 1'b0;

    // Drop valid at the last transfer, drain the owed dots, then let it settle.
    in_valid <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_cnt == 0 && pending_dots.size() == 0) begin
      $display("ellipse_point_generator_core: match");
    end else begin
      $display("ellipse_point_generator_core: mismatch");
    end
    $finish;
  end

endmodule
